/* rtl/twes_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the timing wheel scheduler.
// No dependencies; used by twes_ctrl, twes_dp and timing_wheel_event_scheduler.
package twes_pkg;

    localparam int SLOTS    = 64;
    localparam int PER_SLOT = 8;
    localparam int TAG_BITS = 16;

    localparam int REQ_W   = 2;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 16;
    localparam int SEL_W   = 6;
    localparam int STAT_W  = 3;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int FILL_W  = $clog2(PER_SLOT + 1);
    localparam int TADDR_W = $clog2(SLOTS * PER_SLOT);

    localparam int SLOT_MS   = 100;
    localparam int ROUND_MS  = 50;
    localparam int MIN_AHEAD = 2;
    localparam int LIMIT_MS  = SLOTS * SLOT_MS;

    // (x + 50) / 100 as a multiply by ceil(2^24 / 100) and a shift
    localparam int X_W      = $clog2(LIMIT_MS + ROUND_MS);
    localparam int RECIP_SH = 24;
    localparam int RECIP_K  = ((1 << RECIP_SH) + SLOT_MS - 1) / SLOT_MS;
    localparam int K_W      = $clog2(RECIP_K + 1);
    localparam int PROD_W   = X_W + K_W;
    localparam int AHEAD_W  = SLOT_W + 1;
    localparam int SUM_W    = SLOT_W + 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCHED  = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_SCHEDULED = 3'd0,
        ST_EXPIRED   = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CANCELLED = 3'd5,
        ST_NOT_FOUND = 3'd6
    } stat_t;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  set_slot;
        logic  take_fill;
        logic  scan;
        logic  sched_wr;
        logic  tick_done;
        logic  cancel_done;
        logic  clear;
        logic  emit;
        logic  last;
        stat_t code;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic too_long;
        logic sel_bad;
        logic fill_zero;
        logic fill_full;
        logic rsp_valid;
        logic rsp_last;
        logic found_now;
    } sts_t;

endpackage

/* rtl/timing_wheel_event_scheduler.sv */
// Timing wheel event scheduler top level: controller plus datapath. Uses twes_pkg,
// twes_ctrl and twes_dp.
// Schedule: a request passes the check, slot, wait and fill states; a too-long delay is
// answered from the check state. The next start is accepted in the cycle the result appears.
// Tick and cancel: an empty slot is answered from the fill state, others are scanned;
// the single read port of the tag memory sets one entry per cycle during the scan.
// Reset: fill counts are cleared in a pass over all slots with busy high; results appear
// for one cycle on strobe and the receiver cannot stall.
module timing_wheel_event_scheduler
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [twes_pkg::REQ_W-1:0]   req_type,
    input  logic [twes_pkg::DELAY_W-1:0] delay_ms,
    input  logic [twes_pkg::TAG_W-1:0]   event_tag,
    input  logic [twes_pkg::SEL_W-1:0]   slot_sel,
    output logic                         strobe,
    output logic [twes_pkg::STAT_W-1:0]  status,
    output logic [twes_pkg::TAG_W-1:0]   out_tag,
    output logic [twes_pkg::SEL_W-1:0]   out_slot,
    output logic                         last
);

    twes_pkg::cmd_t cmd;
    twes_pkg::sts_t sts;

    twes_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    twes_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .delay_ms  (delay_ms),
        .event_tag (event_tag),
        .slot_sel  (slot_sel),
        .cmd       (cmd),
        .sts       (sts),
        .strobe    (strobe),
        .status    (status),
        .out_tag   (out_tag),
        .out_slot  (out_slot),
        .last      (last)
    );

endmodule

/* rtl/twes_dp.sv */
// Datapath of the timing wheel scheduler: request registers, slot arithmetic,
// tag and fill-count memories, scan counters and result registers. Uses twes_pkg.
module twes_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [twes_pkg::REQ_W-1:0]   req_type,
    input  logic [twes_pkg::DELAY_W-1:0] delay_ms,
    input  logic [twes_pkg::TAG_W-1:0]   event_tag,
    input  logic [twes_pkg::SEL_W-1:0]   slot_sel,
    input  twes_pkg::cmd_t               cmd,
    output twes_pkg::sts_t               sts,
    output logic                         strobe,
    output logic [twes_pkg::STAT_W-1:0]  status,
    output logic [twes_pkg::TAG_W-1:0]   out_tag,
    output logic [twes_pkg::SEL_W-1:0]   out_slot,
    output logic                         last
);

    logic [twes_pkg::TAG_BITS-1:0] tag_mem [twes_pkg::SLOTS * twes_pkg::PER_SLOT];
    logic [twes_pkg::FILL_W-1:0]   fill_mem [twes_pkg::SLOTS];

    twes_pkg::req_t                req_reg;
    logic [twes_pkg::DELAY_W-1:0]  delay_reg;
    logic [twes_pkg::TAG_BITS-1:0] tag_reg;
    logic [twes_pkg::SEL_W-1:0]    sel_reg;
    logic [twes_pkg::PROD_W-1:0]   prod_reg,    prod_next;
    logic [twes_pkg::SLOT_W-1:0]   wslot_reg,   wslot_next;
    logic [twes_pkg::SLOT_W-1:0]   cur_reg,     cur_next;
    logic [twes_pkg::SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [twes_pkg::FILL_W-1:0]   n_reg,       n_next;
    logic [twes_pkg::FILL_W-1:0]   rd_idx_reg,  rd_idx_next;
    logic [twes_pkg::FILL_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                          pend_reg,    pend_next;
    logic                          found_reg,   found_next;
    logic [twes_pkg::TAG_BITS-1:0] tag_rd_reg;
    logic [twes_pkg::FILL_W-1:0]   fill_rd_reg;

    logic                          strobe_reg,  strobe_next;
    twes_pkg::stat_t               status_reg,  status_next;
    logic [twes_pkg::TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [twes_pkg::SEL_W-1:0]    out_slot_reg, out_slot_next;
    logic                          last_reg,    last_next;

    logic [twes_pkg::X_W-1:0]      round_x;
    logic [twes_pkg::AHEAD_W-1:0]  ahead;
    logic [twes_pkg::AHEAD_W-1:0]  ahead_min;
    logic [twes_pkg::SUM_W-1:0]    slot_sum;
    logic [twes_pkg::SLOT_W-1:0]   slot_calc;
    logic [twes_pkg::TADDR_W-1:0]  base_addr;
    logic [twes_pkg::TADDR_W-1:0]  tag_rd_addr;
    logic [twes_pkg::TADDR_W-1:0]  tag_wr_addr;
    logic [twes_pkg::TAG_BITS-1:0] tag_wr_data;
    logic                          tag_wr_en;
    logic                          shift_wr;
    logic                          issue;
    logic                          match;
    logic                          fill_wr_en;
    logic [twes_pkg::SLOT_W-1:0]   fill_wr_addr;
    logic [twes_pkg::FILL_W-1:0]   fill_wr_data;

    // slot arithmetic
    assign round_x   = twes_pkg::X_W'(delay_reg[twes_pkg::X_W-1:0])
                       + twes_pkg::X_W'(twes_pkg::ROUND_MS);
    assign prod_next = twes_pkg::PROD_W'(round_x) * twes_pkg::PROD_W'(twes_pkg::RECIP_K);
    assign ahead     = twes_pkg::AHEAD_W'(prod_reg >> twes_pkg::RECIP_SH);
    assign ahead_min = (ahead < twes_pkg::AHEAD_W'(twes_pkg::MIN_AHEAD))
                       ? twes_pkg::AHEAD_W'(twes_pkg::MIN_AHEAD) : ahead;
    assign slot_sum  = twes_pkg::SUM_W'(cur_reg) + twes_pkg::SUM_W'(ahead_min);
    assign slot_calc = (slot_sum >= twes_pkg::SUM_W'(twes_pkg::SLOTS))
                       ? twes_pkg::SLOT_W'(slot_sum - twes_pkg::SUM_W'(twes_pkg::SLOTS))
                       : twes_pkg::SLOT_W'(slot_sum);

    // tag memory addressing
    assign base_addr   = twes_pkg::TADDR_W'(wslot_reg) * twes_pkg::TADDR_W'(twes_pkg::PER_SLOT);
    assign tag_rd_addr = base_addr + twes_pkg::TADDR_W'(rd_idx_reg);
    assign issue       = cmd.scan && (rd_idx_reg < n_reg);
    assign match       = (tag_rd_reg == tag_reg);
    assign shift_wr    = cmd.scan && pend_reg && found_reg;
    assign tag_wr_en   = cmd.sched_wr || shift_wr;
    assign tag_wr_addr = cmd.sched_wr
                         ? base_addr + twes_pkg::TADDR_W'(fill_rd_reg)
                         : base_addr + twes_pkg::TADDR_W'(pend_idx_reg - twes_pkg::FILL_W'(1));
    assign tag_wr_data = cmd.sched_wr ? tag_reg : tag_rd_reg;

    // fill count write port
    assign fill_wr_en   = cmd.clear || cmd.sched_wr || cmd.tick_done || cmd.cancel_done;
    assign fill_wr_addr = cmd.clear ? clr_idx_reg : wslot_reg;

    always_comb
    begin
        if (cmd.sched_wr)
        begin
            fill_wr_data = fill_rd_reg + twes_pkg::FILL_W'(1);
        end
        else if (cmd.cancel_done)
        begin
            fill_wr_data = n_reg - twes_pkg::FILL_W'(1);
        end
        else
        begin
            fill_wr_data = '0;
        end
    end

    always_comb
    begin
        wslot_next    = wslot_reg;
        cur_next      = cur_reg;
        clr_idx_next  = clr_idx_reg;
        n_next        = n_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = issue;
        pend_idx_next = issue ? rd_idx_reg : pend_idx_reg;
        found_next    = found_reg;

        if (cmd.clear)
        begin
            clr_idx_next = clr_idx_reg + twes_pkg::SLOT_W'(1);
        end

        if (cmd.set_slot)
        begin
            case (req_reg)
                twes_pkg::REQ_SCHED: wslot_next = slot_calc;
                twes_pkg::REQ_TICK:  wslot_next = cur_reg;
                default:             wslot_next = twes_pkg::SLOT_W'(sel_reg);
            endcase
        end

        if (cmd.take_fill)
        begin
            n_next      = fill_rd_reg;
            rd_idx_next = '0;
            found_next  = 1'b0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + twes_pkg::FILL_W'(1);
        end

        if (cmd.scan && pend_reg && match)
        begin
            found_next = 1'b1;
        end

        if (cmd.tick_done)
        begin
            cur_next = (cur_reg == twes_pkg::SLOT_W'(twes_pkg::SLOTS - 1))
                       ? '0 : cur_reg + twes_pkg::SLOT_W'(1);
        end
    end

    // result selection
    always_comb
    begin
        strobe_next = cmd.emit;
        status_next = cmd.code;
        last_next   = cmd.last;

        case (cmd.code)
            twes_pkg::ST_EXPIRED: out_tag_next = twes_pkg::TAG_W'(tag_rd_reg);
            twes_pkg::ST_EMPTY:   out_tag_next = '0;
            default:              out_tag_next = twes_pkg::TAG_W'(tag_reg);
        endcase

        if (cmd.code == twes_pkg::ST_TOO_LONG)
        begin
            out_slot_next = '0;
        end
        else if (req_reg == twes_pkg::REQ_CANCEL)
        begin
            out_slot_next = sel_reg;
        end
        else
        begin
            out_slot_next = twes_pkg::SEL_W'(wslot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            clr_idx_reg  <= '0;
            n_reg        <= '0;
            rd_idx_reg   <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            cur_reg      <= cur_next;
            clr_idx_reg  <= clr_idx_next;
            n_reg        <= n_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= twes_pkg::req_t'(req_type);
            delay_reg <= delay_ms;
            tag_reg   <= twes_pkg::TAG_BITS'(event_tag);
            sel_reg   <= slot_sel;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        wslot_reg    <= wslot_next;
        pend_idx_reg <= pend_idx_next;
        if (cmd.emit)
        begin
            status_reg   <= status_next;
            out_tag_reg  <= out_tag_next;
            out_slot_reg <= out_slot_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_wr_en)
        begin
            tag_mem[tag_wr_addr] <= tag_wr_data;
        end
        tag_rd_reg <= tag_mem[tag_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fill_wr_en)
        begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
        fill_rd_reg <= fill_mem[wslot_reg];
    end

    assign sts.clr_last  = (clr_idx_reg == twes_pkg::SLOT_W'(twes_pkg::SLOTS - 1));
    assign sts.too_long  = (delay_reg >= twes_pkg::DELAY_W'(twes_pkg::LIMIT_MS));
    assign sts.sel_bad   = (32'(sel_reg) >= 32'(twes_pkg::SLOTS));
    assign sts.fill_zero = (fill_rd_reg == '0);
    assign sts.fill_full = (fill_rd_reg >= twes_pkg::FILL_W'(twes_pkg::PER_SLOT));
    assign sts.rsp_valid = pend_reg;
    assign sts.rsp_last  = pend_reg && (pend_idx_reg == n_reg - twes_pkg::FILL_W'(1));
    assign sts.found_now = found_reg || (pend_reg && match);

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign out_tag  = out_tag_reg;
    assign out_slot = out_slot_reg;
    assign last     = last_reg;

    a_sched_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sched_wr |-> (fill_rd_reg < twes_pkg::FILL_W'(twes_pkg::PER_SLOT)))
        else $error("schedule write into a full slot");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        shift_wr |-> (pend_idx_reg != '0))
        else $error("cancel shift below slot base");

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pend_idx_reg < n_reg))
        else $error("scan response beyond fill count");

    a_tick_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_done |-> (wslot_reg == cur_reg))
        else $error("tick drains a slot other than the current one");

endmodule

/* rtl/twes_ctrl.sv */
// Controller of the timing wheel scheduler: sequences clearing, schedule, tick and cancel
// transactions and issues datapath commands. Uses twes_pkg.
module twes_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [twes_pkg::REQ_W-1:0] req_type,
    input  twes_pkg::sts_t             sts,
    output twes_pkg::cmd_t             cmd,
    output logic                       busy
);

    typedef enum logic [2:0] {
        CLR,
        IDLE,
        S_CHK,
        S_SLOT,
        S_WAIT,
        S_FILL,
        T_SCAN,
        C_SCAN
    } state_t;

    state_t         state_reg, state_next;
    twes_pkg::req_t op_reg,    op_next;

    assign busy = (state_reg != IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;

        case (state_reg)
            CLR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = IDLE;
                end
            end

            IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = twes_pkg::req_t'(req_type);
                    case (twes_pkg::req_t'(req_type))
                        twes_pkg::REQ_SCHED:  state_next = S_CHK;
                        twes_pkg::REQ_TICK,
                        twes_pkg::REQ_CANCEL: state_next = S_SLOT;
                        default:              state_next = IDLE;
                    endcase
                end
            end

            S_CHK:
            begin
                cmd.mul = 1'b1;
                if (sts.too_long)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.code   = twes_pkg::ST_TOO_LONG;
                    state_next = IDLE;
                end
                else
                begin
                    state_next = S_SLOT;
                end
            end

            S_SLOT:
            begin
                if (op_reg == twes_pkg::REQ_CANCEL && sts.sel_bad)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.code   = twes_pkg::ST_NOT_FOUND;
                    state_next = IDLE;
                end
                else
                begin
                    cmd.set_slot = 1'b1;
                    state_next   = S_WAIT;
                end
            end

            S_WAIT:
            begin
                state_next = S_FILL;
            end

            S_FILL:
            begin
                cmd.take_fill = 1'b1;
                case (op_reg)
                    twes_pkg::REQ_SCHED:
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        if (sts.fill_full)
                        begin
                            cmd.code = twes_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.sched_wr = 1'b1;
                            cmd.code     = twes_pkg::ST_SCHEDULED;
                        end
                        state_next = IDLE;
                    end
                    twes_pkg::REQ_TICK:
                    begin
                        if (sts.fill_zero)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.last      = 1'b1;
                            cmd.code      = twes_pkg::ST_EMPTY;
                            cmd.tick_done = 1'b1;
                            state_next    = IDLE;
                        end
                        else
                        begin
                            state_next = T_SCAN;
                        end
                    end
                    default:
                    begin
                        if (sts.fill_zero)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.code   = twes_pkg::ST_NOT_FOUND;
                            state_next = IDLE;
                        end
                        else
                        begin
                            state_next = C_SCAN;
                        end
                    end
                endcase
            end

            T_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.rsp_valid)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = sts.rsp_last;
                    cmd.code = twes_pkg::ST_EXPIRED;
                end
                if (sts.rsp_last)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = IDLE;
                end
            end

            C_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.rsp_last)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (sts.found_now)
                    begin
                        cmd.cancel_done = 1'b1;
                        cmd.code        = twes_pkg::ST_CANCELLED;
                    end
                    else
                    begin
                        cmd.code = twes_pkg::ST_NOT_FOUND;
                    end
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLR;
            op_reg    <= twes_pkg::REQ_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == IDLE))
        else $error("final result not followed by idle");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(cmd.emit || cmd.scan || cmd.sched_wr || cmd.tick_done || cmd.cancel_done))
        else $error("datapath work issued while idle");

endmodule
